@@ hw/rtl/tslbq_pkg.sv @@
`timescale 1ns / 1ps

package tslbq_pkg;

  // Record status codes
  localparam logic [1:0] ST_CLEARED = 2'd0;
  localparam logic [1:0] ST_NOK     = 2'd1;
  localparam logic [1:0] ST_OK      = 2'd2;

  // Fault event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_PASSED = 2'd1;
  localparam logic [1:0] EV_FAILED = 2'd2;

  // Item kinds carried in tuser
  localparam logic [1:0] MODE_TELEGRAM  = 2'd0;
  localparam logic [1:0] MODE_NEW_CYCLE = 2'd1;
  localparam logic [1:0] MODE_CLR_COUNT = 2'd2;
  localparam logic [1:0] MODE_CLR_ALL   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_FAIL_THRESHOLD  = 1'b0;
  localparam logic CFG_GOOD_RX_TO_HEAL = 1'b1;

  localparam logic [3:0] FAIL_THRESHOLD_RST  = 4'd15;
  localparam logic [3:0] GOOD_RX_TO_HEAL_RST = 4'd10;

  // Cycle control value that marks a low battery seen in this driving cycle
  localparam logic [3:0] LOW_MARK = 4'd15;

  localparam logic [3:0] LVL_LOW      = 4'd1;
  localparam logic [3:0] LVL_MAX      = 4'd11;
  localparam logic [3:0] LIFE_MAX     = 4'd10;
  localparam logic [7:0] OUT_TEMP_OFS = 8'd50;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [31:0] id;
    logic [3:0]  count;
    logic [1:0]  status;
    logic [3:0]  life;
    logic [15:0] odometer;
    logic [7:0]  sensor_temp;
    logic [7:0]  outside_temp;
    logic [3:0]  rx_ctrl;
  } record_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [1:0]  wheel;
    logic [3:0]  battery_level;
    logic [31:0] sensor_id;
    logic        force_init;
    logic [31:0] odometer_km;
    logic [7:0]  sensor_temp;
    logic [7:0]  outside_temp;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       record_updated;
    logic [3:0] old_life;
    logic [3:0] new_life;
    logic [1:0] fault_event;
    logic [3:0] fault_count;
  } result_t;

  // Status towards the update logic from the other wheels
  typedef struct packed {
    logic others_ok;
    logic others_zero;
  } peer_t;

endpackage

@@ hw/rtl/tslbq_update.sv @@
`timescale 1ns / 1ps

module tslbq_update (
  input  tslbq_pkg::record_t cur,
  input  tslbq_pkg::item_t   item,
  input  tslbq_pkg::peer_t   peer,
  input  logic [3:0]         fail_threshold,
  input  logic [3:0]         good_rx_to_heal,
  output tslbq_pkg::record_t nxt,
  output logic               upd,
  output logic [1:0]         fault_event
);
  import tslbq_pkg::*;

  logic       id_chg;
  logic       pass;
  logic       fail;
  logic       store_env;
  logic [3:0] ctrl_inc;

  assign id_chg   = (item.sensor_id != cur.id) || item.force_init;
  assign ctrl_inc = cur.rx_ctrl + 4'd1;

  always_comb begin
    nxt       = cur;
    upd       = 1'b0;
    pass      = 1'b0;
    fail      = 1'b0;
    store_env = 1'b0;

    if (id_chg) begin
      nxt.id           = item.sensor_id;
      nxt.count        = 4'd0;
      nxt.odometer     = 16'hFFFF;
      nxt.sensor_temp  = 8'hFF;
      nxt.outside_temp = 8'hFF;
      upd              = 1'b1;
    end

    if (item.battery_level != LVL_LOW) begin
      if (cur.life != item.battery_level &&
          !(item.battery_level == LVL_MAX && cur.life == LIFE_MAX)) begin
        upd      = 1'b1;
        nxt.life = (item.battery_level < LVL_MAX) ? item.battery_level : LIFE_MAX;
      end
      if (cur.status == ST_CLEARED && !item.force_init) begin
        upd = 1'b1;
        if (peer.others_ok) pass = 1'b1;
      end else if (item.force_init && peer.others_ok) begin
        pass = 1'b1;
      end
      nxt.status = ST_OK;
      // count good receptions; heal once when the limit is reached
      if (cur.rx_ctrl != LOW_MARK && cur.rx_ctrl < good_rx_to_heal) begin
        nxt.rx_ctrl = ctrl_inc;
        if (ctrl_inc == good_rx_to_heal && nxt.count != 4'd0) begin
          upd       = 1'b1;
          nxt.count = nxt.count - 4'd1;
          if (nxt.count == 4'd0 && peer.others_zero) pass = 1'b1;
        end
      end
    end else begin
      if (cur.rx_ctrl != LOW_MARK) begin
        nxt.rx_ctrl = LOW_MARK;
        nxt.status  = ST_NOK;
        nxt.life    = LVL_LOW;
        upd         = 1'b1;
        if (nxt.count < fail_threshold) begin
          nxt.count = nxt.count + 4'd1;
          store_env = 1'b1;
          if (nxt.count == fail_threshold) fail = 1'b1;
        end
      end
      if (nxt.life != LVL_LOW) begin
        nxt.status = ST_NOK;
        nxt.life   = LVL_LOW;
        upd        = 1'b1;
      end
    end

    if (store_env) begin
      nxt.odometer     = item.odometer_km[19:4];
      nxt.sensor_temp  = item.sensor_temp;
      nxt.outside_temp = item.outside_temp + OUT_TEMP_OFS;
    end

    fault_event = fail ? EV_FAILED : (pass ? EV_PASSED : EV_NONE);
  end

endmodule

@@ hw/rtl/tire_sensor_low_battery_qualifier.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Signals                         Content
// s_*       in   s_tvalid s_tready s_tdata s_tuser  one telegram or command
// m_*       out  m_tvalid m_tready m_tdata          one result per item
// cfg_*     in   cfg_we cfg_addr cfg_data           fail_threshold, good_rx_to_heal
//
// One item a cycle unless the result stalls: an input register, a single pass of
// update logic, and a result register; the wheel records sit in flops and are
// written as the item moves into the result register.
// rst clears all records and loads the register defaults.
// A stalled result holds the result register; the input register still
// takes one further item.
module tire_sensor_low_battery_qualifier #(
  parameter int NUM_WHEELS = 4
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // wheel[1:0] battery_level[5:2] sensor_id[37:6] force_init[38]
  // odometer_km[70:39] sensor_temp[78:71] outside_temp[86:79] zero[87]
  input  logic [tslbq_pkg::IN_DATA_W-1:0]  s_tdata,
  // mode[1:0]
  input  logic [1:0]                       s_tuser,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // accepted[0] record_updated[1] old_life[5:2] new_life[9:6]
  // fault_event[11:10] fault_count[15:12]
  output logic [tslbq_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                             cfg_we,
  input  logic                             cfg_addr,
  input  logic [3:0]                       cfg_data
);
  import tslbq_pkg::*;

  localparam int WIDX = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  logic [3:0] fail_threshold;
  logic [3:0] good_rx_to_heal;

  record_t rec [NUM_WHEELS];

  logic    in_valid;
  item_t   in_item;
  logic    advance;
  result_t res;

  logic            wheel_ok;
  logic            lvl_ok;
  logic [WIDX-1:0] widx;
  record_t         cur;
  record_t         upd_rec;
  logic            upd;
  logic [1:0]      upd_event;
  peer_t           peer;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      fail_threshold  <= FAIL_THRESHOLD_RST;
      good_rx_to_heal <= GOOD_RX_TO_HEAL_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_FAIL_THRESHOLD:  fail_threshold  <= cfg_data;
        CFG_GOOD_RX_TO_HEAL: good_rx_to_heal <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_item.mode          <= s_tuser;
      in_item.wheel         <= s_tdata[1:0];
      in_item.battery_level <= s_tdata[5:2];
      in_item.sensor_id     <= s_tdata[37:6];
      in_item.force_init    <= s_tdata[38];
      in_item.odometer_km   <= s_tdata[70:39];
      in_item.sensor_temp   <= s_tdata[78:71];
      in_item.outside_temp  <= s_tdata[86:79];
    end
  end

  assign wheel_ok = {30'd0, in_item.wheel} < 32'(NUM_WHEELS);
  assign lvl_ok   = (in_item.battery_level != 4'd0) && (in_item.battery_level <= LVL_MAX);
  assign widx     = WIDX'(in_item.wheel);
  assign cur      = wheel_ok ? rec[widx] : '0;

  always_comb begin
    peer.others_ok   = 1'b1;
    peer.others_zero = 1'b1;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      if (WIDX'(i) != widx) begin
        if (rec[i].status != ST_OK) peer.others_ok = 1'b0;
        if (rec[i].count != 4'd0) peer.others_zero = 1'b0;
      end
    end
  end

  tslbq_update u_update (
    .cur             (cur),
    .item            (in_item),
    .peer            (peer),
    .fail_threshold  (fail_threshold),
    .good_rx_to_heal (good_rx_to_heal),
    .nxt             (upd_rec),
    .upd             (upd),
    .fault_event     (upd_event)
  );

  always_comb begin
    res = '0;
    if (in_item.mode != MODE_TELEGRAM) begin
      res.accepted = 1'b1;
      if (wheel_ok && in_item.mode == MODE_NEW_CYCLE) res.fault_count = cur.count;
    end else if (wheel_ok && lvl_ok) begin
      res.accepted       = 1'b1;
      res.record_updated = upd;
      res.old_life       = cur.life;
      res.new_life       = upd_rec.life;
      res.fault_event    = upd_event;
      res.fault_count    = upd_rec.count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_WHEELS; i++) begin
        rec[i] <= '0;
      end
    end else if (advance) begin
      case (in_item.mode)
        MODE_TELEGRAM: begin
          if (wheel_ok && lvl_ok) begin
            // cycle control always moves; the rest only on a record change
            if (upd) begin
              rec[widx] <= upd_rec;
            end else begin
              rec[widx].rx_ctrl <= upd_rec.rx_ctrl;
            end
          end
        end
        MODE_NEW_CYCLE: begin
          for (int i = 0; i < NUM_WHEELS; i++) rec[i].rx_ctrl <= 4'd0;
        end
        MODE_CLR_COUNT: begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            rec[i].status <= ST_CLEARED;
            rec[i].count  <= 4'd0;
          end
        end
        MODE_CLR_ALL: begin
          for (int i = 0; i < NUM_WHEELS; i++) begin
            rec[i].status       <= ST_OK;
            rec[i].count        <= 4'd0;
            rec[i].odometer     <= 16'hFFFF;
            rec[i].sensor_temp  <= 8'hFF;
            rec[i].outside_temp <= 8'hFF;
            rec[i].life         <= 4'd0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {res.fault_count, res.fault_event, res.new_life, res.old_life,
                  res.record_updated, res.accepted};
    end
  end

endmodule
